// ----- rtl/xor_key_candidate_checker_core_defines.svh -----
// assertion macros for the xor key candidate checker
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef XOR_KEY_CANDIDATE_CHECKER_CORE_DEFINES_SVH
`define XOR_KEY_CANDIDATE_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define XKC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xkc: implication check failed");

// next-cycle implication, disabled in reset
`define XKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xkc: next-cycle check failed");

`endif

// ----- rtl/xkc_pkg.sv -----
// shared types, constants and helpers for the xor key candidate checker
// no dependencies
package xkc_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int KEY_MAX   = 8;
    localparam int CNT_W     = $clog2(MAX_LEN) + 1;
    localparam int KEY_POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int RATIO_W   = 4;
    localparam int PROD_W    = CNT_W + RATIO_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = KEY_W;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATIO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO  = 2'd3;

    localparam logic [LEN_W-1:0]   RST_KEY_LENGTH = 4'd5;
    localparam logic [RATIO_W-1:0] RST_MIN_RATIO  = 4'd6;
    localparam logic [RATIO_W-1:0] RST_MAX_RATIO  = 4'd9;

    // ascii codes used by the word matcher
    localparam logic [7:0]  CHR_SPACE   = 8'h20;
    localparam logic [7:0]  CHR_NUL     = 8'h00;
    localparam logic [7:0]  CHR_A       = 8'h61;
    localparam logic [7:0]  CHR_H       = 8'h68;
    localparam logic [7:0]  CHR_M       = 8'h6D;
    localparam logic [7:0]  CHR_Y       = 8'h79;
    localparam logic [7:0]  CHR_Z       = 8'h7A;
    localparam logic [23:0] TAIL_HOG    = 24'h686F67;
    localparam logic [15:0] TAIL_NE     = 16'h6E65;
    localparam logic [7:0]  UPPER_FIRST = 8'h41;
    localparam logic [7:0]  UPPER_LAST  = 8'h5A;

    typedef struct packed {
        logic [KEY_W-1:0]   key_bytes;
        logic [LEN_W-1:0]   key_length;
        logic [RATIO_W-1:0] min_ratio;
        logic [RATIO_W-1:0] max_ratio;
    } t_cfg;

    typedef struct packed {
        logic [KEY_POS_W-1:0] key_position;
        logic [CNT_W-1:0]     byte_count;
        logic [CNT_W-1:0]     space_count;
    } t_msg_status;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       plausible;
    } t_msg_result;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
            return c | 8'h20;
        end
        return c;
    endfunction

endpackage

// ----- rtl/xkc_in_if.sv -----
// input channel of the xor key candidate checker: ciphertext items
// depends on nothing
interface xkc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last;

    modport source (output valid, output cipher_byte, output last, input ready);
    modport sink   (input valid, input cipher_byte, input last, output ready);
endinterface

// ----- rtl/xkc_out_if.sv -----
// output channel of the xor key candidate checker: plain items and verdict
// depends on nothing
interface xkc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       is_last;
    logic       plausible;

    modport source (output valid, output plain_byte, output is_last, output plausible,
                    input ready);
    modport sink   (input valid, input plain_byte, input is_last, input plausible,
                    output ready);
endinterface

// ----- rtl/xkc_cfg_regs.sv -----
// configuration registers: key, key length and ratio bounds
// depends on xkc_pkg
module xkc_cfg_regs
    import xkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_bytes  <= '0;
            r_cfg.key_length <= RST_KEY_LENGTH;
            r_cfg.min_ratio  <= RST_MIN_RATIO;
            r_cfg.max_ratio  <= RST_MAX_RATIO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:  r_cfg.key_bytes  <= i_cfg_data[KEY_W-1:0];
                CFG_KEY_LENGTH: r_cfg.key_length <= i_cfg_data[LEN_W-1:0];
                CFG_MIN_RATIO:  r_cfg.min_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_MAX_RATIO:  r_cfg.max_ratio  <= i_cfg_data[RATIO_W-1:0];
                default:        r_cfg.key_bytes  <= r_cfg.key_bytes;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/xkc_msg_state.sv -----
// per-message state: key rotation, counts, word matcher and verdict
// depends on xkc_pkg
module xkc_msg_state
    import xkc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_step,
    input  logic [7:0]  i_cipher_byte,
    input  logic        i_last,
    output t_msg_result o_result,
    output t_msg_status o_status
);

    logic [KEY_POS_W-1:0] r_key_pos, n_key_pos;
    logic [CNT_W-1:0]     r_byte_cnt, n_byte_cnt;
    logic [CNT_W-1:0]     r_space_cnt, n_space_cnt;
    logic [23:0]          r_recent, n_recent;
    logic [3:0]           r_words, n_words;
    logic                 r_zero, n_zero;

    logic [7:0]        plain;
    logic [7:0]        low_c;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  pos_inc;
    logic [PROD_W-1:0] lo_bound;
    logic [PROD_W-1:0] hi_bound;
    logic              ratio_ok;

    assign plain = i_cipher_byte ^ i_cfg.key_bytes[{r_key_pos, 3'b000} +: 8];
    assign low_c = lower_ascii(plain);

    // zero length acts as one, anything beyond the key store is clamped
    always_comb begin
        if (i_cfg.key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_cfg.key_length > LEN_W'(KEY_MAX)) begin
            eff_len = LEN_W'(KEY_MAX);
        end else begin
            eff_len = i_cfg.key_length;
        end
    end

    assign pos_inc = LEN_W'(r_key_pos) + LEN_W'(1);

    always_comb begin
        n_key_pos   = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_POS_W-1:0];
        n_byte_cnt  = r_byte_cnt;
        n_space_cnt = r_space_cnt;
        n_recent    = r_recent;
        n_words     = r_words;
        n_zero      = r_zero;
        // bytes past the length cap are decrypted but leave the stats alone
        if (r_byte_cnt < CNT_W'(MAX_LEN)) begin
            n_byte_cnt = r_byte_cnt + CNT_W'(1);
            if (plain == CHR_SPACE) begin
                n_space_cnt = r_space_cnt + CNT_W'(1);
            end
            if (plain == CHR_NUL) begin
                n_zero = 1'b1;
            end
            if (!n_zero) begin
                if (low_c == CHR_Y && r_recent == TAIL_HOG)      n_words[0] = 1'b1;
                if (low_c == CHR_M && r_recent[15:0] == TAIL_NE) n_words[1] = 1'b1;
                if (low_c == CHR_Z && r_recent[7:0] == CHR_A)    n_words[2] = 1'b1;
                if (low_c == CHR_A && r_recent[7:0] == CHR_H)    n_words[3] = 1'b1;
                n_recent = {r_recent[15:0], low_c};
            end
        end
    end

    // exact ratio test by cross-multiplication
    assign lo_bound = PROD_W'(i_cfg.min_ratio) * PROD_W'(n_space_cnt);
    assign hi_bound = PROD_W'(i_cfg.max_ratio) * PROD_W'(n_space_cnt);
    assign ratio_ok = (lo_bound < PROD_W'(n_byte_cnt)) && (PROD_W'(n_byte_cnt) < hi_bound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos   <= '0;
            r_byte_cnt  <= '0;
            r_space_cnt <= '0;
            r_recent    <= '0;
            r_words     <= '0;
            r_zero      <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_key_pos   <= '0;
                r_byte_cnt  <= '0;
                r_space_cnt <= '0;
                r_recent    <= '0;
                r_words     <= '0;
                r_zero      <= 1'b0;
            end else begin
                r_key_pos   <= n_key_pos;
                r_byte_cnt  <= n_byte_cnt;
                r_space_cnt <= n_space_cnt;
                r_recent    <= n_recent;
                r_words     <= n_words;
                r_zero      <= n_zero;
            end
        end
    end

    assign o_result.plain_byte = plain;
    assign o_result.plausible  = i_last && ratio_ok && (n_words == 4'hF);

    assign o_status.key_position = r_key_pos;
    assign o_status.byte_count   = r_byte_cnt;
    assign o_status.space_count  = r_space_cnt;

endmodule

// ----- rtl/xor_key_candidate_checker_core.sv -----
// top level of the xor key candidate checker: input register, message state, result register
// depends on xkc_pkg, xkc_in_if, xkc_out_if, xkc_cfg_regs, xkc_msg_state and the defines header
`include "xor_key_candidate_checker_core_defines.svh"

// Decrypts a message one ciphertext item at a time with a repeating key of
// 1 to 8 bytes and returns one plain item per input item via the input and
// result registers. One item is accepted per clock while the output is not
// stalled; the throughput is set by the state update (key position, byte and
// space counts, last three lower-case bytes, word flags) between the two
// registers. The result of the item marked last carries the verdict: plausible
// when min_ratio*spaces < length < max_ratio*spaces and the words hogy, nem, az
// and ha were all seen (case-insensitive, not after a zero byte). Statistics
// stop at 4096 bytes; later bytes are still decrypted. The user must write
// configuration through the plain write port only while no item is in flight;
// not enforced by the block. After the last item all per-message state resets.
module xor_key_candidate_checker_core
    import xkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    xkc_in_if.sink               i_in,
    xkc_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // input register stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // result register stage
    logic       r_out_valid;
    logic [7:0] r_out_plain;
    logic       r_out_last;
    logic       r_out_plaus;

    logic        in_acc;
    logic        advance;
    t_cfg        cfg;
    t_msg_result result;
    t_msg_status status;

    // the held item moves on whenever the result register is free or being drained
    assign advance    = r_s1_valid && (!r_out_valid || o_out.ready);
    // the input register takes a new item when empty or when its item moves on
    assign i_in.ready = !r_s1_valid || advance;
    assign in_acc     = i_in.valid && i_in.ready;

    xkc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // state only moves on the cycle its item is committed to the result register
    xkc_msg_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (advance),
        .i_cipher_byte (r_s1_byte),
        .i_last        (r_s1_last),
        .o_result      (result),
        .o_status      (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_in.cipher_byte;
            r_s1_last <= i_in.last;
        end
        if (advance) begin
            r_out_plain <= result.plain_byte;
            r_out_last  <= r_s1_last;
            r_out_plaus <= result.plausible;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.plain_byte = r_out_plain;
    assign o_out.is_last    = r_out_last;
    assign o_out.plausible  = r_out_plaus;

    // a verdict only ever rides on the final item of a message
    `XKC_ASSERT_IMPLIES(a_plaus_on_last, r_out_valid && r_out_plaus, r_out_last)
    // spaces are a subset of the counted bytes, and the count is capped
    `XKC_ASSERT_IMPLIES(a_counts_sane, 1'b1,
        status.space_count <= status.byte_count && status.byte_count <= CNT_W'(MAX_LEN))
    // committing the final item returns the message state to its start
    `XKC_ASSERT_NEXT(a_clear_after_last, advance && r_s1_last,
        status.byte_count == '0 && status.space_count == '0 && status.key_position == '0)
    // a committed item always shows up in the result register
    `XKC_ASSERT_NEXT(a_commit_visible, advance, r_out_valid)

endmodule
